/* hw/rtl/linked_list_engine_core_defines.svh */
// assertion macros for the list engine
`ifndef LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define LINKED_LIST_ENGINE_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define LLE_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define LLE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

/* hw/rtl/lle_pkg.sv */
package lle_pkg;

   localparam int unsigned CapacityDefault   = 32;
   localparam int unsigned ValueWidthDefault = 32;
   localparam int unsigned FieldWidth        = 32;
   localparam int unsigned PosWidth          = 6;

   typedef enum logic [2:0] {
      OP_INS_HEAD   = 3'd0,
      OP_INS_TAIL   = 3'd1,
      OP_INS_AFTER  = 3'd2,
      OP_INS_BEFORE = 3'd3,
      OP_DELETE     = 3'd4,
      OP_LIST       = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]                   op;
      logic signed [FieldWidth-1:0] item_value;
      logic signed [FieldWidth-1:0] reference_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [FieldWidth-1:0] out_value;
      logic [PosWidth-1:0]          position;
      logic                         last;
   } rsp_type;

endpackage

/* hw/rtl/lle_rsp_reg.sv */
// output register that parts the walk sequencer from the result channel
module lle_rsp_reg
   import lle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // hold one beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

/* hw/rtl/linked_list_engine_core.sv */
// channel | dir | beat content
// req     | in  | op, item_value, reference_value
// rsp     | out | status, out_value, position, last
// each item walks the list one node per cycle through a single link/value read port;
// an item runs from S_IDLE to S_FIN through S_WALK, S_LINK or S_LIST as needed; an unused op is dropped in S_IDLE,
// and listing gives one beat per node as taken.
// after reset a clearing pass over all CAPACITY nodes chains the free list; req_ready stays low.
// a stalled rsp channel holds the listing; req_ready is high only while the sequencer is idle.
module linked_list_engine_core
   import lle_pkg::*;
#(
   parameter int unsigned CAPACITY    = CapacityDefault,
   parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned IW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [IW-1:0] NIL = IW'(CAPACITY);

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_WALK, S_LINK, S_LIST, S_FIN
   } state_type;

   state_type state_ff;
   logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
   logic [IW-1:0]          link_mem [CAPACITY];

   logic [IW-1:0]  head_ff, free_ff, cur_ff, prev_ff, newn_ff, node_ff;
   logic [IW-1:0]  steps_ff;
   logic [2:0]     op_ff;
   logic [VALUE_WIDTH-1:0] item_ff, key_ff;
   logic [IW-1:0]  link_rd;
   logic [VALUE_WIDTH-1:0] val_rd;
   logic [PosWidth-1:0] pos_ff;
   logic           emit_in;
   rsp_type        emit_data;
   logic           emit_ready;
   logic [1:0]     phase_ff;

   // sign-extend or cut a 32-bit field to the stored width
   function automatic logic [VALUE_WIDTH-1:0] to_stored(input logic [FieldWidth-1:0] f);
      logic [VALUE_WIDTH+FieldWidth-1:0] w;
      w = {{VALUE_WIDTH{f[FieldWidth-1]}}, f};
      return w[VALUE_WIDTH-1:0];
   endfunction

   // stored value to the 32-bit result field
   function automatic logic [FieldWidth-1:0] to_field(input logic [VALUE_WIDTH-1:0] v);
      logic [VALUE_WIDTH+FieldWidth-1:0] w;
      w = {{FieldWidth{1'b0}}, v};
      return w[FieldWidth-1:0];
   endfunction

   // combinational read of current node
   assign link_rd = (cur_ff < NIL) ? link_mem[cur_ff[AW-1:0]] : NIL;
   assign val_rd  = val_mem[cur_ff[AW-1:0]];

   assign req_ready = (state_ff == S_IDLE);

   // one sequencer, one read port, one compare
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         head_ff  <= NIL;
         free_ff  <= '0;
         cur_ff   <= '0;
         emit_in  <= 1'b0;
      end else begin
         if (emit_in && emit_ready) begin
            emit_in <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               link_mem[cur_ff[AW-1:0]] <= cur_ff + IW'(1);
               if (cur_ff == NIL - IW'(1)) begin
                  state_ff <= S_IDLE;
               end
               cur_ff <= cur_ff + IW'(1);
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_data.op;
                  item_ff  <= to_stored(req_data.item_value);
                  key_ff   <= (req_data.op == OP_DELETE) ? to_stored(req_data.item_value)
                                                         : to_stored(req_data.reference_value);
                  cur_ff   <= head_ff;
                  prev_ff  <= NIL;
                  steps_ff <= '0;
                  pos_ff   <= '0;
                  phase_ff <= 2'd0;
                  if (req_data.op <= OP_INS_BEFORE && free_ff >= NIL) begin
                     emit_data <= '{status: ST_FULL, out_value: '0, position: '0, last: 1'b1};
                     emit_in   <= 1'b1;
                     state_ff  <= S_FIN;
                  end else if (req_data.op == OP_INS_HEAD) begin
                     newn_ff  <= free_ff;
                     state_ff <= S_LINK;
                  end else if (req_data.op == OP_LIST && head_ff >= NIL) begin
                     emit_data <= '{status: ST_EMPTY, out_value: '0, position: '0, last: 1'b1};
                     emit_in   <= 1'b1;
                     state_ff  <= S_FIN;
                  end else if (req_data.op == OP_LIST) begin
                     state_ff <= S_LIST;
                  end else if (req_data.op <= OP_DELETE) begin
                     newn_ff  <= free_ff;
                     state_ff <= S_WALK;
                  end
               end
            end
            S_WALK: begin
               if (op_ff == OP_INS_TAIL) begin
                  // find last node
                  if (cur_ff >= NIL) begin
                     state_ff <= S_LINK;
                  end else if (link_rd >= NIL || steps_ff >= NIL) begin
                     node_ff  <= cur_ff;
                     state_ff <= S_LINK;
                  end else begin
                     cur_ff   <= link_rd;
                     steps_ff <= steps_ff + IW'(1);
                  end
               end else begin
                  if (cur_ff >= NIL || steps_ff >= NIL) begin
                     emit_data <= '{status: ST_NOT_FOUND, out_value: '0, position: '0,
                                    last: 1'b1};
                     emit_in   <= 1'b1;
                     state_ff  <= S_FIN;
                  end else if (val_rd == key_ff) begin
                     node_ff  <= cur_ff;
                     state_ff <= S_LINK;
                  end else begin
                     prev_ff  <= cur_ff;
                     cur_ff   <= link_rd;
                     steps_ff <= steps_ff + IW'(1);
                  end
               end
            end
            S_LINK: begin
               if (phase_ff == 2'd3) begin
                  emit_data <= '{status: ST_OK, out_value: '0, position: '0, last: 1'b1};
                  emit_in   <= 1'b1;
                  state_ff  <= S_FIN;
               end else begin
                  // phase 0 reads the free head or unlinks, later phases pop the free node and relink
                  case (op_ff)
                     OP_INS_HEAD: begin
                        if (phase_ff == 2'd0) begin
                           cur_ff   <= free_ff;
                           phase_ff <= 2'd1;
                        end else begin
                           free_ff <= link_rd;
                           val_mem[newn_ff[AW-1:0]]  <= item_ff;
                           link_mem[newn_ff[AW-1:0]] <= head_ff;
                           head_ff  <= newn_ff;
                           phase_ff <= 2'd3;
                        end
                     end
                     OP_INS_TAIL: begin
                        if (phase_ff == 2'd0) begin
                           node_ff  <= (cur_ff >= NIL) ? NIL : node_ff;
                           cur_ff   <= free_ff;
                           phase_ff <= 2'd1;
                        end else begin
                           free_ff <= link_rd;
                           val_mem[newn_ff[AW-1:0]]  <= item_ff;
                           link_mem[newn_ff[AW-1:0]] <= NIL;
                           if (node_ff >= NIL) begin
                              head_ff <= newn_ff;
                           end else begin
                              link_mem[node_ff[AW-1:0]] <= newn_ff;
                           end
                           phase_ff <= 2'd3;
                        end
                     end
                     OP_INS_AFTER, OP_INS_BEFORE: begin
                        if (phase_ff == 2'd0) begin
                           cur_ff   <= free_ff;
                           phase_ff <= 2'd1;
                        end else if (phase_ff == 2'd1) begin
                           free_ff  <= link_rd;
                           val_mem[newn_ff[AW-1:0]] <= item_ff;
                           cur_ff   <= node_ff;
                           phase_ff <= 2'd2;
                        end else begin
                           if (op_ff == OP_INS_AFTER) begin
                              link_mem[newn_ff[AW-1:0]] <= link_rd;
                              link_mem[node_ff[AW-1:0]] <= newn_ff;
                           end else begin
                              link_mem[newn_ff[AW-1:0]] <= node_ff;
                              if (prev_ff >= NIL) begin
                                 head_ff <= newn_ff;
                              end else begin
                                 link_mem[prev_ff[AW-1:0]] <= newn_ff;
                              end
                           end
                           phase_ff <= 2'd3;
                        end
                     end
                     default: begin
                        // delete: cur_ff still points at the matched node
                        if (prev_ff >= NIL) begin
                           head_ff <= link_rd;
                        end else begin
                           link_mem[prev_ff[AW-1:0]] <= link_rd;
                        end
                        link_mem[node_ff[AW-1:0]] <= free_ff;
                        free_ff  <= node_ff;
                        phase_ff <= 2'd3;
                     end
                  endcase
               end
            end
            S_LIST: begin
               // one beat per node
               if (!emit_in || emit_ready) begin
                  emit_data <= '{status: ST_OK, out_value: to_field(val_rd),
                                 position: pos_ff + PosWidth'(1),
                                 last: (link_rd >= NIL || steps_ff + IW'(1) >= NIL)};
                  emit_in   <= 1'b1;
                  pos_ff    <= pos_ff + PosWidth'(1);
                  steps_ff  <= steps_ff + IW'(1);
                  cur_ff    <= link_rd;
                  if (link_rd >= NIL || steps_ff + IW'(1) >= NIL) begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_FIN: begin
               if (!emit_in || emit_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   lle_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit_in),
      .in_ready  (emit_ready),
      .in_data   (emit_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

/* hw/rtl/lle_checker.sv */
`include "linked_list_engine_core_defines.svh"

// port-level checks on the list engine
module lle_checker
   import lle_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // unused opcodes are dropped at once; any other accepted opcode drops req_ready
   `LLE_ASSERT_NEXT(a_no_req_after_accept, clock, reset,
      req_valid && req_ready && req_data.op <= OP_LIST, !req_ready)
   `LLE_ASSERT_IMP(a_zero_pos_not_listing, clock, reset,
      rsp_valid && rsp_data.status != ST_OK, rsp_data.position == '0 && rsp_data.last)
   `LLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))
   `LLE_ASSERT_IMP(a_nonok_zero_value, clock, reset,
      rsp_valid && rsp_data.status != ST_OK, rsp_data.out_value == '0)

endmodule

bind linked_list_engine_core lle_checker u_lle_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/linked_list_engine_checker.sv */
module linked_list_engine_checker
   import lle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count,
   output int      rsp_seen
);

   localparam int Cap = CapacityDefault;
   localparam int Nil = Cap;

   // shadow copy of the node stores
   logic signed [31:0] node_value [Cap];
   int                 node_link  [Cap];
   int                 list_head;
   int                 free_top;
   int                 list_len;
   rsp_type            rsp_pending [$];

   function automatic int find_first(input logic signed [31:0] val, output int prev);
      int cur;
      int steps;
      cur   = list_head;
      prev  = Nil;
      steps = 0;
      while (cur < Nil && steps < Cap) begin
         if (node_value[cur] == val) return cur;
         prev = cur;
         cur  = node_link[cur];
         steps++;
      end
      prev = Nil;
      return Nil;
   endfunction

   function automatic int grab_node(input logic signed [31:0] val);
      int n;
      n             = free_top;
      free_top      = node_link[n];
      node_value[n] = val;
      node_link[n]  = Nil;
      list_len++;
      return n;
   endfunction

   function automatic void push_status(input status_type st);
      rsp_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      rsp_pending.push_back(r);
   endfunction

   // predicted beats for one request
   function automatic void apply_request(input req_type rq);
      int      n;
      int      node;
      int      prev;
      int      t;
      int      k;
      rsp_type r;
      if (rq.op <= OP_INS_BEFORE) begin
         if (free_top >= Nil) begin
            push_status(ST_FULL);
            return;
         end
         case (rq.op)
            OP_INS_HEAD: begin
               n            = grab_node(rq.item_value);
               node_link[n] = list_head;
               list_head    = n;
            end
            OP_INS_TAIL: begin
               n = grab_node(rq.item_value);
               if (list_head >= Nil) list_head = n;
               else begin
                  t = list_head;
                  k = 0;
                  while (node_link[t] < Nil && k < Cap) begin
                     t = node_link[t];
                     k++;
                  end
                  node_link[t] = n;
               end
            end
            default: begin
               node = find_first(rq.reference_value, prev);
               if (node >= Nil) begin
                  push_status(ST_NOT_FOUND);
                  return;
               end
               n = grab_node(rq.item_value);
               if (rq.op == OP_INS_AFTER) begin
                  node_link[n]    = node_link[node];
                  node_link[node] = n;
               end else begin
                  node_link[n] = node;
                  if (prev >= Nil) list_head = n;
                  else node_link[prev] = n;
               end
            end
         endcase
         push_status(ST_OK);
      end else if (rq.op == OP_DELETE) begin
         node = find_first(rq.item_value, prev);
         if (node >= Nil) begin
            push_status(ST_NOT_FOUND);
            return;
         end
         if (prev >= Nil) list_head = node_link[node];
         else node_link[prev] = node_link[node];
         node_link[node] = free_top;
         free_top        = node;
         if (list_len > 0) list_len--;
         push_status(ST_OK);
      end else if (rq.op == OP_LIST) begin
         if (list_head >= Nil) begin
            push_status(ST_EMPTY);
            return;
         end
         t = list_head;
         k = 0;
         while (t < Nil && k < Cap) begin
            r           = '0;
            r.status    = ST_OK;
            r.out_value = node_value[t];
            r.position  = 6'(k + 1);
            r.last      = (node_link[t] >= Nil || k + 1 >= Cap);
            rsp_pending.push_back(r);
            t = node_link[t];
            k++;
         end
      end
   endfunction

   assign pending_count = rsp_pending.size();

   // watch both channels at each edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < Cap; i++) begin
            node_value[i] = '0;
            node_link[i]  = i + 1;
         end
         list_head = Nil;
         free_top  = 0;
         list_len  = 0;
         rsp_pending.delete();
         error_count <= 0;
         rsp_seen    <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (rsp_pending.size() == 0) begin
               $display("%0t unexpected beat %p", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = rsp_pending.pop_front();
               if (want.status != rsp_data.status || want.out_value != rsp_data.out_value ||
                   want.position != rsp_data.position || want.last != rsp_data.last) begin
                  $display("%0t mismatch expected %p actual %p", $time, want, rsp_data);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) apply_request(req_data);
      end
   end

endmodule

/* verif/tb_linked_list_engine_core.sv */
module tb_linked_list_engine_core;
   import lle_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      rsp_seen;
   int      req_sent = 0;
   bit      long_hold = 1'b0;
   logic signed [31:0] value_pool [8];

   always #10 clock = ~clock;

   linked_list_engine_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   linked_list_engine_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .rsp_seen      (rsp_seen)
   );

   // one beat on the request channel, held until taken
   task automatic send_req(input logic [2:0] op, input logic signed [31:0] item,
                           input logic signed [31:0] ref_val);
      req_valid <= 1'b1;
      req_data  <= '{op: op, item_value: item, reference_value: ref_val};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_sent++;
   endtask

   task automatic idle_cycles(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value;
      case ($urandom_range(0, 3))
         0: return $urandom;
         default: return value_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   // receiver stall pattern, with one long hold
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         phase++;
         if (phase % 200 < 60) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // stimulus
   initial begin
      int burst;
      logic [2:0] op;
      for (int i = 0; i < 8; i++) value_pool[i] = $urandom;
      value_pool[0] = 32'sh7fffffff;
      value_pool[1] = 32'sh80000000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-list corners, extremes, duplicates
      send_req(OP_LIST, 0, 0);
      send_req(OP_INS_AFTER, 5, 5);
      send_req(OP_INS_BEFORE, 5, 5);
      send_req(OP_DELETE, 5, 0);
      send_req(3'd6, 1, 1);
      send_req(3'd7, -1, -1);
      send_req(OP_INS_HEAD, 32'sh7fffffff, 0);
      send_req(OP_INS_TAIL, 32'sh80000000, 0);
      send_req(OP_INS_TAIL, 0, 0);
      send_req(OP_INS_AFTER, -1, 32'sh80000000);
      send_req(OP_INS_BEFORE, 7, 32'sh7fffffff);
      send_req(OP_INS_HEAD, 0, 0);
      send_req(OP_INS_BEFORE, 9, 0);
      send_req(OP_INS_AFTER, 3, 1234);
      send_req(OP_LIST, 0, 0);
      send_req(OP_DELETE, 0, 0);
      send_req(OP_DELETE, 7, 0);
      send_req(OP_LIST, 0, 0);
      drain();

      // fill to capacity with the receiver held off, then overflow
      long_hold = 1'b1;
      for (int i = 0; i < 30; i++) send_req(OP_INS_TAIL, $urandom, 0);
      send_req(OP_INS_HEAD, -1, 0);
      send_req(OP_INS_AFTER, 1, -1);
      send_req(OP_INS_TAIL, 2, 0);
      send_req(OP_INS_BEFORE, 3, -1);
      send_req(OP_LIST, 0, 0);
      drain();
      for (int i = 0; i < 32; i++) send_req(OP_DELETE, 0, 0);
      send_req(OP_LIST, 0, 0);
      for (int i = 0; i < 32; i++) send_req(OP_DELETE, $urandom, 0);
      drain();

      // random bursts over a small value pool so searches hit
      while (req_sent < 400) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            op = $urandom_range(0, 20) == 0 ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
            if (op == OP_LIST && $urandom_range(0, 2) != 0) op = OP_INS_TAIL;
            send_req(op, pick_value(), pick_value());
         end
         if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 20));
      end
      drain();

      $display("covered %0d requests and %0d response beats, incl. empty, full and missing cases",
               req_sent, rsp_seen);
      if (error_count == 0) $display("PASS linked_list_engine_core");
      else $display("FAIL linked_list_engine_core");
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL linked_list_engine_core");
      $finish;
   end

endmodule
